/* design/sao_pkg.sv */
// Shared types, constants and arm decision tables for the sonar/arm obstacle fusion block.
`default_nettype none
package sao_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CMP_W       = (SUM_W > 16) ? SUM_W : 16;
    localparam int DCNT_W      = $clog2(SUM_W + 1);
    localparam int IDX_W       = 3;

    localparam logic [3:0] DIR_NONE = 4'd0;
    localparam logic [3:0] DIR_N    = 4'd1;
    localparam logic [3:0] DIR_NE   = 4'd2;
    localparam logic [3:0] DIR_E    = 4'd3;
    localparam logic [3:0] DIR_SE   = 4'd4;
    localparam logic [3:0] DIR_S    = 4'd5;
    localparam logic [3:0] DIR_SW   = 4'd6;
    localparam logic [3:0] DIR_W    = 4'd7;
    localparam logic [3:0] DIR_NW   = 4'd8;

    localparam logic [1:0] DET_NONE   = 2'd0;
    localparam logic [1:0] DET_ARMS   = 2'd1;
    localparam logic [1:0] DET_SONARS = 2'd2;

    localparam logic [IDX_W-1:0] REG_USE_ARMS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_USE_LEFT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_USE_RIGHT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FRONT_UPPER = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIDE_UPPER  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LOWER       = 3'd5;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } sample_pair_t;

    typedef struct packed {
        logic             busy;
        logic [SUM_W-1:0] quotient;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic is_backward(logic [3:0] d);
        return (d inside {DIR_S, DIR_SE, DIR_SW});
    endfunction

    function automatic logic is_forward(logic [3:0] d);
        return (d inside {DIR_N, DIR_NE, DIR_NW});
    endfunction

    function automatic logic [3:0] left_only_map(logic [3:0] d);
        logic [3:0] r;
        case (d)
            DIR_N:   r = DIR_SW;
            DIR_NE:  r = DIR_SW;
            DIR_E:   r = DIR_W;
            DIR_SE:  r = DIR_NW;
            DIR_S:   r = DIR_NW;
            DIR_SW:  r = DIR_N;
            DIR_W:   r = DIR_S;
            DIR_NW:  r = DIR_S;
            default: r = DIR_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] right_only_map(logic [3:0] d);
        logic [3:0] r;
        case (d)
            DIR_N:   r = DIR_SE;
            DIR_NE:  r = DIR_S;
            DIR_E:   r = DIR_S;
            DIR_SE:  r = DIR_N;
            DIR_S:   r = DIR_NE;
            DIR_SW:  r = DIR_NE;
            DIR_W:   r = DIR_E;
            DIR_NW:  r = DIR_SE;
            default: r = DIR_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] arms_decide(logic [3:0] left, logic [3:0] right);
        logic [3:0] r;
        if (is_backward(right) && is_backward(left))
            r = DIR_N;
        else if (is_forward(right) && is_forward(left))
            r = DIR_S;
        else if (right == DIR_NONE)
            r = left_only_map(left);
        else if (left == DIR_NONE)
            r = right_only_map(right);
        else
            r = DIR_NONE;
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/sao_cell.sv */
// One window cell: holds a left/right sample pair and passes it on to the next cell.
`default_nettype none
module sao_cell
    import sao_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         shift,
    input  wire sample_pair_t d,
    output sample_pair_t      q
);

    sample_pair_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule
`default_nettype wire

/* design/sao_div.sv */
// Restoring divider, one quotient bit per cycle, for the window sum over the fill count.
`default_nettype none
module sao_div
    import sao_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output div_stat_t             stat
);

    logic              busy_reg,    busy_next;
    logic [DCNT_W-1:0] cnt_reg,     cnt_next;
    logic [SUM_W-1:0]  quo_reg,     quo_next;
    logic [CNT_W-1:0]  rem_reg,     rem_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial        = {rem_reg, quo_reg[SUM_W-1]};
        diff         = trial - {1'b0, divisor_reg};
        ge           = (trial >= {1'b0, divisor_reg});
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = DCNT_W'(SUM_W);
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.quotient = quo_reg;

endmodule
`default_nettype wire

/* design/sonar_arm_obstacle_fusion.sv */
// Top level: sonar window chain, averaging dividers, thresholds and arm/sonar merge.
`default_nettype none
// One word per frame in, one word out. With either sonar enabled a frame is handled in
// order: it shifts the sample pair into the window chain, updates the sums and loads the
// dividers; the bit-serial divisions of both sums by the fill count run side by side
// until the sequencer sees them finish; then it is classified and merged into the output
// register. With both sonars disabled a frame skips the divisions. A new frame is taken
// while the previous result still waits in the output register; that frame then holds in
// its final step until the waiting word is taken.
module sonar_arm_obstacle_fusion
    import sao_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // config write channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [15:0]      cfg_data,
    // [15:0] left_sonar, [31:16] right_sonar, [35:32] left_arm_push, [39:36] right_arm_push
    input  wire logic [39:0]      s_tdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // [3:0] direction, [20:4] distance_mm, [22:21] detector, [23] zero
    output logic [23:0]           m_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready
);

    logic        use_arms_reg;
    logic        use_left_reg;
    logic        use_right_reg;
    logic [15:0] front_upper_reg;
    logic [15:0] side_upper_reg;
    logic [15:0] lower_reg;

    state_t state_reg, state_next;

    logic [SUM_W-1:0] left_sum_reg,  left_sum_next;
    logic [SUM_W-1:0] right_sum_reg, right_sum_next;
    logic [CNT_W-1:0] fill_reg,      fill_next;
    logic             sonar_on_reg;
    logic [3:0]       left_arm_reg;
    logic [3:0]       right_arm_reg;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [3:0]  dir_reg,  dir_next;
    logic [16:0] dist_reg, dist_next;
    logic [1:0]  det_reg,  det_next;

    logic         accept;
    logic         sonar_on;
    logic         full;
    logic         load_out;
    sample_pair_t new_pair;
    sample_pair_t cell_q [WINDOW];
    div_stat_t    left_div;
    div_stat_t    right_div;

    logic [CMP_W-1:0] lavg;
    logic [CMP_W-1:0] ravg;
    logic [CMP_W-1:0] front_t;
    logic [CMP_W-1:0] side_t;
    logic [CMP_W-1:0] lower_t;
    logic [CMP_W:0]   pair_sum;
    logic [CMP_W-1:0] sonar_dist;
    logic [3:0]       sonars;
    logic [3:0]       arms;
    logic [3:0]       dir_c;
    logic [1:0]       det_c;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign sonar_on  = use_left_reg || use_right_reg;
    assign full      = (fill_reg == CNT_W'(WINDOW));
    assign load_out  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign new_pair.left  = SAMPLE_BITS'(s_tdata[15:0]);
    assign new_pair.right = SAMPLE_BITS'(s_tdata[31:16]);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_arms_reg    <= 1'b0;
            use_left_reg    <= 1'b0;
            use_right_reg   <= 1'b0;
            front_upper_reg <= 16'd900;
            side_upper_reg  <= 16'd700;
            lower_reg       <= 16'd250;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_USE_ARMS:    use_arms_reg    <= cfg_data[0];
                REG_USE_LEFT:    use_left_reg    <= cfg_data[0];
                REG_USE_RIGHT:   use_right_reg   <= cfg_data[0];
                REG_FRONT_UPPER: front_upper_reg <= cfg_data;
                REG_SIDE_UPPER:  side_upper_reg  <= cfg_data;
                REG_LOWER:       lower_reg       <= cfg_data;
                default:         ;
            endcase
        end
    end

    // window chain; the tail cell holds the oldest sample once full
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                sao_cell u_cell (
                    .clk   (clk),
                    .shift (accept && sonar_on),
                    .d     (new_pair),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                sao_cell u_cell (
                    .clk   (clk),
                    .shift (accept && sonar_on),
                    .d     (cell_q[gi-1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        fill_next      = fill_reg;
        if (accept && sonar_on)
        begin
            left_sum_next  = left_sum_reg
                           - (full ? SUM_W'(cell_q[WINDOW-1].left) : '0)
                           + SUM_W'(new_pair.left);
            right_sum_next = right_sum_reg
                           - (full ? SUM_W'(cell_q[WINDOW-1].right) : '0)
                           + SUM_W'(new_pair.right);
            fill_next      = full ? fill_reg : fill_reg + 1'b1;
        end
    end

    sao_div u_div_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && sonar_on),
        .dividend (left_sum_next),
        .divisor  (fill_next),
        .stat     (left_div)
    );

    sao_div u_div_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && sonar_on),
        .dividend (right_sum_next),
        .divisor  (fill_next),
        .stat     (right_div)
    );

    // classification and merge
    always_comb
    begin
        front_t  = CMP_W'(front_upper_reg);
        side_t   = CMP_W'(side_upper_reg);
        lower_t  = CMP_W'(lower_reg);
        lavg     = use_left_reg  ? CMP_W'(left_div.quotient)  : front_t;
        ravg     = use_right_reg ? CMP_W'(right_div.quotient) : front_t;
        pair_sum = {1'b0, lavg} + {1'b0, ravg};
        sonars     = DIR_NONE;
        sonar_dist = '0;
        if (sonar_on_reg)
        begin
            if (ravg < front_t && lavg < front_t && ravg > lower_t && lavg > lower_t)
            begin
                sonars     = DIR_N;
                sonar_dist = pair_sum[CMP_W:1];
            end
            else if (ravg < side_t && ravg > lower_t)
            begin
                sonars     = DIR_NE;
                sonar_dist = ravg;
            end
            else if (lavg < side_t && lavg > lower_t)
            begin
                sonars     = DIR_NW;
                sonar_dist = lavg;
            end
        end
        arms = use_arms_reg ? arms_decide(left_arm_reg, right_arm_reg) : DIR_NONE;
        if (arms == sonars)
        begin
            dir_c = arms;
            det_c = DET_ARMS;
        end
        else if (arms == DIR_NONE)
        begin
            dir_c = sonars;
            det_c = DET_SONARS;
        end
        else if (sonars == DIR_N && (arms == DIR_NW || arms == DIR_NE))
        begin
            dir_c = arms;
            det_c = DET_ARMS;
        end
        else if (arms == DIR_N && (sonars == DIR_NW || sonars == DIR_NE))
        begin
            dir_c = sonars;
            det_c = DET_SONARS;
        end
        else
        begin
            dir_c = arms;
            det_c = DET_ARMS;
        end

        dir_next      = dir_reg;
        dist_next     = dist_reg;
        det_next      = det_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            dir_next      = dir_c;
            if (dir_c == DIR_NONE)
            begin
                det_next  = DET_NONE;
                dist_next = '0;
            end
            else if (det_c == DET_ARMS)
            begin
                det_next  = DET_ARMS;
                dist_next = '1;
            end
            else
            begin
                det_next  = DET_SONARS;
                dist_next = (sonar_dist > CMP_W'(65535)) ? 17'd65535
                                                         : {1'b0, sonar_dist[15:0]};
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sonar_on ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (!left_div.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
            fill_reg      <= '0;
            sonar_on_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
            fill_reg      <= fill_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (accept)
            begin
                sonar_on_reg <= sonar_on;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_arm_reg  <= s_tdata[35:32];
            right_arm_reg <= s_tdata[39:36];
        end
        dir_reg  <= dir_next;
        dist_reg <= dist_next;
        det_reg  <= det_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, det_reg, dist_reg, dir_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sonar_on) |=> (state_reg == ST_DIV && left_div.busy && right_div.busy))
        else $error("dividers not started with sonar frame");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        left_div.busy == right_div.busy)
        else $error("dividers out of step");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result not presented");

endmodule
`default_nettype wire

/* verif/sonar_arm_obstacle_fusion_checker.sv */
// Checker for the obstacle fusion block: tracks register writes, predicts each report, compares.
`timescale 1ns / 100ps
module sonar_arm_obstacle_fusion_checker
    import sao_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic [39:0]      s_tdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [23:0]      m_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    output int               fail_count,
    output int               pending,
    output int               checked
);

    // same layout as m_tdata[22:0]
    typedef struct packed {
        logic [1:0]  det;
        logic [16:0] distance;
        logic [3:0]  dir;
    } report_t;

    // single-arm direction tables, entry 0 in the low nibble
    localparam logic [63:0] LEFT_ALONE = {{7{DIR_NONE}}, DIR_S, DIR_S, DIR_N, DIR_NW,
                                          DIR_NW, DIR_W, DIR_SW, DIR_SW, DIR_NONE};
    localparam logic [63:0] RIGHT_ALONE = {{7{DIR_NONE}}, DIR_SE, DIR_E, DIR_NE, DIR_NE,
                                           DIR_N, DIR_S, DIR_S, DIR_SE, DIR_NONE};

    logic        arms_on, left_on, right_on;
    logic [15:0] front_mm, side_mm, lower_mm;
    sample_t     left_hist  [WINDOW];
    sample_t     right_hist [WINDOW];
    int unsigned left_total, right_total, slot, filled;
    report_t     expected_reports [$];
    int          mismatches, reports_seen;

    function automatic logic [3:0] arm_verdict(logic [3:0] l, logic [3:0] r);
        logic l_back, r_back, l_fwd, r_fwd;
        l_back = (l == DIR_S) || (l == DIR_SE) || (l == DIR_SW);
        r_back = (r == DIR_S) || (r == DIR_SE) || (r == DIR_SW);
        l_fwd  = (l == DIR_N) || (l == DIR_NE) || (l == DIR_NW);
        r_fwd  = (r == DIR_N) || (r == DIR_NE) || (r == DIR_NW);
        if (l_back && r_back)
            return DIR_N;
        if (l_fwd && r_fwd)
            return DIR_S;
        if (r == DIR_NONE)
            return LEFT_ALONE[4*l +: 4];
        if (l == DIR_NONE)
            return RIGHT_ALONE[4*r +: 4];
        return DIR_NONE;
    endfunction

    // advances the sonar windows and returns the report for one frame
    function automatic report_t fuse_frame(logic [39:0] w);
        sample_t     l_mm, r_mm;
        logic [3:0]  arms, sonars;
        int unsigned l_avg, r_avg, s_dist;
        report_t     rep;
        l_mm   = w[15:0];
        r_mm   = w[31:16];
        arms   = arms_on ? arm_verdict(w[35:32], w[39:36]) : DIR_NONE;
        sonars = DIR_NONE;
        s_dist = 0;
        if (left_on || right_on)
        begin
            if (filled >= WINDOW)
            begin
                left_total  -= left_hist[slot];
                right_total -= right_hist[slot];
            end
            else
            begin
                filled++;
            end
            left_hist[slot]  = l_mm;
            right_hist[slot] = r_mm;
            left_total  += l_mm;
            right_total += r_mm;
            slot  = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            l_avg = left_on  ? left_total / filled  : front_mm;
            r_avg = right_on ? right_total / filled : front_mm;
            if (r_avg < front_mm && l_avg < front_mm && r_avg > lower_mm && l_avg > lower_mm)
            begin
                sonars = DIR_N;
                s_dist = (r_avg + l_avg) >> 1;
            end
            else if (r_avg < side_mm && r_avg > lower_mm)
            begin
                sonars = DIR_NE;
                s_dist = r_avg;
            end
            else if (l_avg < side_mm && l_avg > lower_mm)
            begin
                sonars = DIR_NW;
                s_dist = l_avg;
            end
        end
        if (arms == sonars)
        begin
            rep.dir = arms;
            rep.det = DET_ARMS;
        end
        else if (arms == DIR_NONE)
        begin
            rep.dir = sonars;
            rep.det = DET_SONARS;
        end
        else if (sonars == DIR_N && (arms == DIR_NW || arms == DIR_NE))
        begin
            rep.dir = arms;
            rep.det = DET_ARMS;
        end
        else if (arms == DIR_N && (sonars == DIR_NW || sonars == DIR_NE))
        begin
            rep.dir = sonars;
            rep.det = DET_SONARS;
        end
        else
        begin
            rep.dir = arms;
            rep.det = DET_ARMS;
        end
        if (rep.dir == DIR_NONE)
        begin
            rep.det      = DET_NONE;
            rep.distance = '0;
        end
        else if (rep.det == DET_ARMS)
        begin
            rep.distance = '1;
        end
        else
        begin
            rep.distance = (s_dist > 65535) ? 17'd65535 : 17'(s_dist);
        end
        return rep;
    endfunction

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            if (mismatches < 10)
                $display("report %0d: %s expected 'h%0h, got 'h%0h",
                         reports_seen, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        report_t want, got;
        if (!rst_n)
        begin
            arms_on      = 1'b0;
            left_on      = 1'b0;
            right_on     = 1'b0;
            front_mm     = 16'd900;
            side_mm      = 16'd700;
            lower_mm     = 16'd250;
            left_total   = 0;
            right_total  = 0;
            slot         = 0;
            filled       = 0;
            mismatches   = 0;
            reports_seen = 0;
            expected_reports.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = report_t'(m_tdata[22:0]);
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("report %0d arrived with none outstanding: 'h%0h",
                                 reports_seen, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    check_field("direction", want.dir, got.dir);
                    check_field("distance_mm", want.distance, got.distance);
                    check_field("detector", want.det, got.det);
                end
                reports_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_USE_ARMS:    arms_on  = cfg_data[0];
                    REG_USE_LEFT:    left_on  = cfg_data[0];
                    REG_USE_RIGHT:   right_on = cfg_data[0];
                    REG_FRONT_UPPER: front_mm = cfg_data;
                    REG_SIDE_UPPER:  side_mm  = cfg_data;
                    REG_LOWER:       lower_mm = cfg_data;
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_reports.insert(expected_reports.size(), fuse_frame(s_tdata));
        end
        fail_count <= mismatches;
        pending    <= expected_reports.size();
        checked    <= reports_seen;
    end

endmodule

/* verif/sonar_arm_obstacle_fusion_tb.sv */
// Testbench top for the obstacle fusion block: clock, reset, frame and register stimulus, verdict.
`timescale 1ns / 100ps
module sonar_arm_obstacle_fusion_tb;
    import sao_pkg::*;

    localparam int               CYCLE_LIMIT = 1_000_000;
    localparam int               SETTLE      = SUM_W + 4;
    localparam logic [IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [3:0]       ARM_BOGUS   = 4'd15;
    localparam logic [3:0]       ARM_NINE    = 4'd9;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [15:0]      cfg_data  = '0;
    logic [39:0]      s_tdata   = '0;
    logic             s_tvalid  = 1'b0;
    logic             m_tready  = 1'b0;
    logic             cfg_ready, s_tready, m_tvalid;
    logic [23:0]      m_tdata;

    int          fail_count, pending, checked;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          frames_sent    = 0;
    int          settings_used  = 1;
    int          cycles         = 0;
    logic [15:0] front_cur = 16'd900;
    logic [15:0] side_cur  = 16'd700;
    logic [15:0] lower_cur = 16'd250;

    sonar_arm_obstacle_fusion dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    sonar_arm_obstacle_fusion_checker fusion_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sonar_arm_obstacle_fusion test failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic set_idle(int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
            default: begin src_idle_pct = 18; sink_stall_pct = 18; end
        endcase
    endtask

    task automatic send_frame(logic [15:0] l, logic [15:0] r, logic [3:0] la, logic [3:0] ra);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_tdata  <= {ra, la, r, l};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        frames_sent++;
    endtask

    // waits for the block to drain, then writes every register and one unused index
    task automatic apply_cfg(logic [15:0] arms, logic [15:0] left, logic [15:0] right,
                             logic [15:0] front, logic [15:0] side, logic [15:0] lower);
        logic [IDX_W-1:0] idx  [7];
        logic [15:0]      vals [7];
        idx  = '{REG_USE_ARMS, REG_USE_LEFT, REG_USE_RIGHT, REG_FRONT_UPPER,
                 REG_SIDE_UPPER, REG_LOWER, REG_UNUSED};
        vals = '{arms, left, right, front, side, lower, 16'($urandom)};
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 7; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        front_cur = front;
        side_cur  = side;
        lower_cur = lower;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(7))
            0:       return lower_cur;
            1:       return lower_cur + 16'd1;
            2:       return side_cur - 16'd1;
            3:       return side_cur;
            4:       return front_cur - 16'd1;
            5:       return front_cur;
            6:       return 16'($urandom_range(1500));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] wobble();
        return $urandom_range(1) ? 16'($urandom_range(40) - 20) : 16'd0;
    endfunction

    // steady runs near the thresholds so the averages settle, with some noise
    task automatic random_frames(int n);
        logic [15:0] l_base, r_base, l_mm, r_mm;
        logic [3:0]  la, ra;
        int          run_len;
        run_len = 0;
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
                set_idle($urandom_range(3));
            if (run_len == 0)
            begin
                l_base  = pick_level();
                r_base  = pick_level();
                run_len = $urandom_range(12, 1);
            end
            run_len--;
            l_mm = l_base + wobble();
            r_mm = r_base + wobble();
            if ($urandom_range(9) == 0)
            begin
                l_mm = 16'($urandom);
                r_mm = 16'($urandom);
            end
            case ($urandom_range(9))
                0:       {la, ra} = 8'($urandom);
                1, 2, 3: begin la = 4'($urandom_range(8)); ra = DIR_NONE; end
                4, 5, 6: begin la = DIR_NONE; ra = 4'($urandom_range(8)); end
                default: begin la = 4'($urandom_range(8)); ra = 4'($urandom_range(8)); end
            endcase
            send_frame(l_mm, r_mm, la, ra);
        end
    endtask

    initial
    begin
        logic [15:0] f, s;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: everything disabled, windows untouched
        send_frame(16'd0, 16'd0, DIR_S, DIR_SW);
        send_frame(16'hFFFF, 16'hFFFF, DIR_NW, DIR_N);
        send_frame(16'd1234, 16'd300, ARM_BOGUS, ARM_BOGUS);

        apply_cfg(16'd1, 16'd1, 16'd1, 16'd900, 16'd700, 16'd250);
        send_frame(16'd0, 16'd0, DIR_NONE, DIR_NONE);
        send_frame(16'hFFFF, 16'hFFFF, DIR_NONE, DIR_NONE);
        repeat (6) send_frame(16'd600, 16'd600, DIR_NONE, DIR_NONE);
        send_frame(16'd600, 16'd600, DIR_SE, DIR_SW);
        send_frame(16'd600, 16'd600, DIR_N, DIR_NW);
        send_frame(16'd600, 16'd600, DIR_SE, DIR_NONE);
        send_frame(16'd600, 16'd600, DIR_NONE, DIR_SE);
        send_frame(16'd600, 16'd600, ARM_NINE, DIR_NONE);
        send_frame(16'd600, 16'd600, ARM_BOGUS, DIR_S);
        repeat (6) send_frame(16'd1000, 16'd500, DIR_NONE, DIR_NONE);
        send_frame(16'd1000, 16'd500, DIR_NONE, DIR_NE);
        send_frame(16'd1000, 16'd500, DIR_W, DIR_W);
        send_frame(16'd1000, 16'd500, DIR_NONE, DIR_SE);
        random_frames(200);

        // enables carry junk in the upper bits
        apply_cfg(16'h0003, 16'h8001, 16'd0, 16'd900, 16'd700, 16'd250);
        random_frames(150);
        apply_cfg(16'd0, 16'hFFFE, 16'd1, 16'd1200, 16'd1000, 16'd100);
        random_frames(150);
        apply_cfg(16'd1, 16'd0, 16'd0, 16'd800, 16'd600, 16'd300);
        random_frames(150);
        apply_cfg(16'd1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
        random_frames(150);
        apply_cfg(16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'hFFFF);
        random_frames(100);
        f = 16'($urandom_range(2000, 200));
        s = 16'($urandom_range(f, 100));
        apply_cfg(16'd1, 16'd1, 16'd1, f, s, 16'($urandom_range(s)));
        random_frames(150);
        apply_cfg(16'd1, 16'd1, 16'd1, 16'd600, 16'd900, 16'd0);
        random_frames(150);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);

        $display("%0d frames sent under %0d register settings, %0d reports checked",
                 frames_sent, settings_used, checked);
        $display("idle mixes: none, sender 65%%, receiver 65%%, both 18%%; %0d mismatches",
                 fail_count);
        if (fail_count == 0)
            $display("sonar_arm_obstacle_fusion test passed");
        else
            $display("sonar_arm_obstacle_fusion test failed");
        $finish;
    end

endmodule

/* files.f */
design/sao_pkg.sv
design/sao_cell.sv
design/sao_div.sv
design/sonar_arm_obstacle_fusion.sv
verif/sonar_arm_obstacle_fusion_checker.sv
verif/sonar_arm_obstacle_fusion_tb.sv
